// ----- hdl/tal_pkg.sv -----
// Shared constants, table and types for the thermistor averaging and lookup core.
package tal_pkg;

    // Sizing of the averaging ring and the table walk
    localparam int SAMPLES_AVERAGED = 8;
    localparam int TABLE_ENTRIES    = 100;
    localparam int SAMPLE_BITS      = 10;

    // Port field widths
    localparam int SAMPLE_IN_W = 10;
    localparam int TEMP_W      = 7;
    localparam int AVG_OUT_W   = 10;

    // Stored thermistor table
    localparam int STORED_ENTRIES = 100;
    localparam int TBL_VAL_W      = 10;
    localparam int TBL_IDX_W      = $clog2(STORED_ENTRIES);

    // Derived widths
    localparam int SCAN_LEN = (TABLE_ENTRIES < STORED_ENTRIES) ? TABLE_ENTRIES : STORED_ENTRIES;
    localparam int IDX_W    = $clog2(SCAN_LEN + 1);
    localparam int SLOT_W   = (SAMPLES_AVERAGED > 1) ? $clog2(SAMPLES_AVERAGED) : 1;
    localparam int SUM_W    = SAMPLE_BITS + $clog2(SAMPLES_AVERAGED);
    localparam int CMP_W    = (SAMPLE_BITS > TBL_VAL_W) ? SAMPLE_BITS : TBL_VAL_W;

    // ADC code per degree Celsius, rising
    localparam logic [TBL_VAL_W-1:0] THERMO_TABLE [STORED_ENTRIES] = '{
        10'd229, 10'd239, 10'd249, 10'd259, 10'd270, 10'd280, 10'd291, 10'd302, 10'd313, 10'd324,
        10'd335, 10'd347, 10'd358, 10'd370, 10'd382, 10'd394, 10'd405, 10'd417, 10'd429, 10'd441,
        10'd453, 10'd465, 10'd477, 10'd489, 10'd500, 10'd512, 10'd524, 10'd535, 10'd547, 10'd558,
        10'd569, 10'd580, 10'd591, 10'd602, 10'd613, 10'd623, 10'd633, 10'd644, 10'd654, 10'd663,
        10'd673, 10'd682, 10'd692, 10'd701, 10'd710, 10'd718, 10'd727, 10'd735, 10'd743, 10'd751,
        10'd759, 10'd766, 10'd774, 10'd781, 10'd788, 10'd795, 10'd801, 10'd808, 10'd814, 10'd820,
        10'd826, 10'd832, 10'd837, 10'd843, 10'd848, 10'd853, 10'd858, 10'd863, 10'd867, 10'd872,
        10'd876, 10'd881, 10'd885, 10'd889, 10'd893, 10'd897, 10'd900, 10'd904, 10'd907, 10'd911,
        10'd914, 10'd917, 10'd920, 10'd923, 10'd926, 10'd929, 10'd931, 10'd934, 10'd936, 10'd939,
        10'd941, 10'd944, 10'd946, 10'd948, 10'd950, 10'd952, 10'd954, 10'd956, 10'd958, 10'd960
    };

    // Table entry at a walk index; past the stored entries reads all ones
    function automatic logic [TBL_VAL_W-1:0] thermo_entry(input logic [IDX_W-1:0] idx);
        logic [TBL_IDX_W-1:0] j;
        j = TBL_IDX_W'(idx);
        if (32'(idx) < STORED_ENTRIES)
            return THERMO_TABLE[j];
        else
            return '1;
    endfunction

    // Status of the table walker toward the control logic
    typedef struct packed {
        logic             done;
        logic [IDX_W-1:0] index;
    } scan_status_t;

endpackage

// ----- hdl/tal_ring.sv -----
// Sample ring: synchronous memory with registered read and per-slot valid bits.
module tal_ring (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       rd_en,
    input  logic [tal_pkg::SLOT_W-1:0] rd_slot,
    output logic [tal_pkg::SAMPLE_BITS-1:0] rd_data,
    input  logic                       wr_en,
    input  logic [tal_pkg::SLOT_W-1:0] wr_slot,
    input  logic [tal_pkg::SAMPLE_BITS-1:0] wr_data
);
    import tal_pkg::*;

    logic [SAMPLE_BITS-1:0]      mem [SAMPLES_AVERAGED];
    logic [SAMPLE_BITS-1:0]      rd_raw_reg;
    logic [SAMPLES_AVERAGED-1:0] written_reg;
    logic                        rd_hit_reg;

    // Storage array, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_slot] <= wr_data;
        end
        if (rd_en)
        begin
            rd_raw_reg <= mem[rd_slot];
        end
    end

    // Slots never written since reset read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
            rd_hit_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                written_reg[wr_slot] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_hit_reg <= written_reg[rd_slot];
            end
        end
    end

    assign rd_data = rd_hit_reg ? rd_raw_reg : '0;

endmodule

// ----- hdl/tal_scan.sv -----
// Table walker: one compare per cycle against the thermistor table.
module tal_scan (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [tal_pkg::CMP_W-1:0]   average,
    output tal_pkg::scan_status_t       status
);
    import tal_pkg::*;

    logic [CMP_W-1:0] avg_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             busy_reg;
    logic             done_reg;
    logic             hit;
    logic             at_end;

    // Stop at first entry >= average or at the end of the table
    assign hit    = avg_reg <= CMP_W'(thermo_entry(idx_reg));
    assign at_end = 32'(idx_reg) == SCAN_LEN;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            avg_reg <= average;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            idx_reg  <= '0;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            if (at_end || hit)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    assign status.done  = done_reg;
    assign status.index = idx_reg;

endmodule

// ----- hdl/thermistor_average_lookup_core.sv -----
// Thermistor averaging and lookup core: ring update, mean and table walk.
// Steps: ring read on input transfer, ring write and sum update in ACCUM, walker start, walk in SCAN (index 0..100).
// A new sample is taken only after the table walk of the last one has ended and its result is registered.
// An input is taken only when idle; a finished result may wait in the output register.
// Reset (rst_n, async, active low) clears ring valid bits, write slot, sum and handshakes.
module thermistor_average_lookup_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            sample_valid,
    output logic                            sample_stall,
    input  logic [tal_pkg::SAMPLE_IN_W-1:0] sample,
    output logic                            result_valid,
    input  logic                            result_stall,
    output logic [tal_pkg::TEMP_W-1:0]      temperature,
    output logic [tal_pkg::AVG_OUT_W-1:0]   filtered_average
);
    import tal_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ACCUM,
        S_START,
        S_SCAN
    } state_t;

    state_t                 state_reg;
    state_t                 state_next;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [SLOT_W-1:0]      slot_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic [CMP_W-1:0]       avg_reg;
    logic                   result_valid_reg;
    logic [TEMP_W-1:0]      temperature_reg;
    logic [AVG_OUT_W-1:0]   average_reg;

    logic                   in_xfer;
    logic                   out_free;
    logic [SAMPLE_BITS-1:0] old_sample;
    logic [CMP_W-1:0]       avg_calc;
    scan_status_t           scan_st;

    assign sample_stall = state_reg != S_IDLE;
    assign in_xfer      = sample_valid && !sample_stall;
    assign out_free     = !result_valid_reg || !result_stall;
    assign avg_calc     = CMP_W'(sum_reg / SAMPLES_AVERAGED);

    // Ring memory: read the outgoing slot on transfer, write back in ACCUM
    tal_ring u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_xfer),
        .rd_slot (slot_reg),
        .rd_data (old_sample),
        .wr_en   (state_reg == S_ACCUM),
        .wr_slot (slot_reg),
        .wr_data (sample_reg)
    );

    tal_scan u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (state_reg == S_START),
        .average (avg_calc),
        .status  (scan_st)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (in_xfer) state_next = S_ACCUM;
            S_ACCUM: state_next = S_START;
            S_START: state_next = S_SCAN;
            S_SCAN:  if (scan_st.done && out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            sample_reg <= SAMPLE_BITS'(sample);
        end
        if (state_reg == S_START)
        begin
            avg_reg <= avg_calc;
        end
        if (state_reg == S_SCAN && scan_st.done && out_free)
        begin
            temperature_reg <= TEMP_W'(scan_st.index);
            average_reg     <= avg_reg[AVG_OUT_W-1:0];
        end
    end

    // Control state, ring pointer, running sum, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            slot_reg         <= '0;
            sum_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_ACCUM)
            begin
                sum_reg <= sum_reg - SUM_W'(old_sample) + SUM_W'(sample_reg);
                if (32'(slot_reg) == SAMPLES_AVERAGED - 1)
                    slot_reg <= '0;
                else
                    slot_reg <= slot_reg + 1'b1;
            end
            if (state_reg == S_SCAN && scan_st.done && out_free)
                result_valid_reg <= 1'b1;
            else if (!result_stall)
                result_valid_reg <= 1'b0;
        end
    end

    assign result_valid     = result_valid_reg;
    assign temperature      = temperature_reg;
    assign filtered_average = average_reg;

endmodule

// ----- hdl/tal_checker.sv -----
// Port-level checker for the thermistor averaging and lookup core, with its bind.
module tal_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            sample_valid,
    input logic                            sample_stall,
    input logic                            result_valid,
    input logic                            result_stall,
    input logic [tal_pkg::TEMP_W-1:0]      temperature,
    input logic [tal_pkg::AVG_OUT_W-1:0]   filtered_average
);
    import tal_pkg::*;

    // A stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(temperature)
            && $stable(filtered_average))
        else $error("stalled result changed");

    // One item at a time: the input stalls right after a transfer
    a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && !sample_stall |=> sample_stall)
        else $error("input not stalled after transfer");

    // Temperature never beyond the walked table length
    a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> 32'(temperature) <= SCAN_LEN)
        else $error("temperature out of range");

    // Coldest reading maps to index zero, and only it
    a_first_entry: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ((temperature == '0) ==
            (CMP_W'(filtered_average) <= CMP_W'(THERMO_TABLE[0]))))
        else $error("temperature inconsistent with average at first entry");

endmodule

bind thermistor_average_lookup_core tal_checker u_tal_checker (.*);

// ----- sim/tb_thermistor_average_lookup_core.sv -----
`timescale 1ns / 100ps
// Testbench for the thermistor averaging and lookup core: directed table, random readings, scoreboard.
module tb_thermistor_average_lookup_core;
    import tal_pkg::*;

    localparam int TOTAL_READINGS = 1850;
    localparam int RING_DEPTH     = 8;
    localparam int CURVE_LEN      = 100;
    localparam int BACKLOG_CYCLES = 600;
    localparam int QUIET_LIMIT    = 5000;
    localparam int DRAIN_CYCLES   = 150;

    // Thermistor curve, ADC code per degree, rising
    localparam logic [9:0] CAL_CURVE [CURVE_LEN] = '{
        10'd229, 10'd239, 10'd249, 10'd259, 10'd270, 10'd280, 10'd291, 10'd302, 10'd313, 10'd324,
        10'd335, 10'd347, 10'd358, 10'd370, 10'd382, 10'd394, 10'd405, 10'd417, 10'd429, 10'd441,
        10'd453, 10'd465, 10'd477, 10'd489, 10'd500, 10'd512, 10'd524, 10'd535, 10'd547, 10'd558,
        10'd569, 10'd580, 10'd591, 10'd602, 10'd613, 10'd623, 10'd633, 10'd644, 10'd654, 10'd663,
        10'd673, 10'd682, 10'd692, 10'd701, 10'd710, 10'd718, 10'd727, 10'd735, 10'd743, 10'd751,
        10'd759, 10'd766, 10'd774, 10'd781, 10'd788, 10'd795, 10'd801, 10'd808, 10'd814, 10'd820,
        10'd826, 10'd832, 10'd837, 10'd843, 10'd848, 10'd853, 10'd858, 10'd863, 10'd867, 10'd872,
        10'd876, 10'd881, 10'd885, 10'd889, 10'd893, 10'd897, 10'd900, 10'd904, 10'd907, 10'd911,
        10'd914, 10'd917, 10'd920, 10'd923, 10'd926, 10'd929, 10'd931, 10'd934, 10'd936, 10'd939,
        10'd941, 10'd944, 10'd946, 10'd948, 10'd950, 10'd952, 10'd954, 10'd956, 10'd958, 10'd960
    };

    typedef struct packed {
        logic [TEMP_W-1:0]    temp;
        logic [AVG_OUT_W-1:0] avg;
    } reading_t;

    // Directed row: sample, whether the result is typed in, and that result
    typedef struct packed {
        logic [SAMPLE_IN_W-1:0] value;
        logic                   fixed;
        logic [TEMP_W-1:0]      temp;
        logic [AVG_OUT_W-1:0]   avg;
    } plan_row_t;

    // Warm-up from zero, fill with full scale and wrap, then the top table edges
    localparam int PLAN_LEN = 25;
    localparam plan_row_t WARMUP_PLAN [PLAN_LEN] = '{
        '{10'd0,    1'b1, 7'd0,   10'd0},
        '{10'd1023, 1'b0, 7'd0,   10'd0},
        '{10'd1023, 1'b0, 7'd0,   10'd0},
        '{10'd1023, 1'b0, 7'd0,   10'd0},
        '{10'd1023, 1'b0, 7'd0,   10'd0},
        '{10'd1023, 1'b0, 7'd0,   10'd0},
        '{10'd1023, 1'b0, 7'd0,   10'd0},
        '{10'd1023, 1'b0, 7'd0,   10'd0},
        '{10'd1023, 1'b1, 7'd100, 10'd1023},
        '{10'd961,  1'b0, 7'd0,   10'd0},
        '{10'd961,  1'b0, 7'd0,   10'd0},
        '{10'd961,  1'b0, 7'd0,   10'd0},
        '{10'd961,  1'b0, 7'd0,   10'd0},
        '{10'd961,  1'b0, 7'd0,   10'd0},
        '{10'd961,  1'b0, 7'd0,   10'd0},
        '{10'd961,  1'b0, 7'd0,   10'd0},
        '{10'd961,  1'b1, 7'd100, 10'd961},
        '{10'd960,  1'b0, 7'd0,   10'd0},
        '{10'd960,  1'b0, 7'd0,   10'd0},
        '{10'd960,  1'b0, 7'd0,   10'd0},
        '{10'd960,  1'b0, 7'd0,   10'd0},
        '{10'd960,  1'b0, 7'd0,   10'd0},
        '{10'd960,  1'b0, 7'd0,   10'd0},
        '{10'd960,  1'b0, 7'd0,   10'd0},
        '{10'd960,  1'b1, 7'd99,  10'd960}
    };

    logic                   clk;
    logic                   rst_n;
    logic                   sample_valid;
    logic                   sample_stall;
    logic [SAMPLE_IN_W-1:0] sample;
    logic                   result_valid;
    logic                   result_stall;
    logic [TEMP_W-1:0]      temperature;
    logic [AVG_OUT_W-1:0]   filtered_average;

    // Typed-in result travelling with the current sample
    logic                   row_fixed;
    logic [TEMP_W-1:0]      row_temp;
    logic [AVG_OUT_W-1:0]   row_avg;

    // Predictor state
    logic [9:0]  ring_copy [RING_DEPTH];
    logic [2:0]  slot_next;
    logic [12:0] sum_acc;

    reading_t    pending_readings [$];
    int          mismatch_count;
    int          readings_taken;
    int          quiet_cycles;
    bit          backlog_done;

    thermistor_average_lookup_core i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .sample_valid     (sample_valid),
        .sample_stall     (sample_stall),
        .sample           (sample),
        .result_valid     (result_valid),
        .result_stall     (result_stall),
        .temperature      (temperature),
        .filtered_average (filtered_average)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    task automatic report_mismatch(input string what);
        $display("%0t ns  mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Ring update, truncated mean and first curve entry at or above it
    task automatic average_and_lookup(input logic [9:0] reading, output reading_t res);
        logic [9:0] avg;
        int         idx;
        sum_acc              = sum_acc - 13'(ring_copy[slot_next]) + 13'(reading);
        ring_copy[slot_next] = reading;
        slot_next            = slot_next + 3'd1;
        avg                  = 10'(sum_acc / RING_DEPTH);
        idx                  = 0;
        while (idx < CURVE_LEN && avg > CAL_CURVE[idx])
            idx++;
        res.temp = TEMP_W'(idx);
        res.avg  = avg;
    endtask

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 4);
        else
            return $urandom_range(15, 70);
    endfunction

    // Level near a curve entry, one below, on, or one above it
    function automatic logic [9:0] curve_level();
        int k;
        k = $urandom_range(0, CURVE_LEN - 1);
        return 10'(int'(CAL_CURVE[k]) + $urandom_range(0, 2) - 1);
    endfunction

    // Predict on every input transfer, check on every output transfer
    always @(posedge clk) begin : scoreboard
        reading_t want;
        if (rst_n) begin
            if (sample_valid && !sample_stall) begin
                average_and_lookup(sample, want);
                if (row_fixed) begin
                    want.temp = row_temp;
                    want.avg  = row_avg;
                end
                pending_readings.push_back(want);
                readings_taken++;
            end
            if (result_valid && !result_stall) begin
                if (pending_readings.size() == 0) begin
                    report_mismatch($sformatf("result with nothing pending: temp %0d avg %0d",
                                              temperature, filtered_average));
                end
                else begin
                    want = pending_readings.pop_front();
                    if (temperature !== want.temp)
                        report_mismatch($sformatf("temperature %0d, want %0d",
                                                  temperature, want.temp));
                    if (filtered_average !== want.avg)
                        report_mismatch($sformatf("filtered_average %0d, want %0d",
                                                  filtered_average, want.avg));
                end
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk) begin
        if (rst_n) begin
            if ((sample_valid && !sample_stall) || (result_valid && !result_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // Result side: random stalls, with one long hold-off to back up the core once 40 readings are in
    initial begin : receiver
        int mode;
        int span;
        result_stall <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (!backlog_done && readings_taken >= 40) begin
                result_stall <= 1'b1;
                repeat (BACKLOG_CYCLES) @(posedge clk);
                backlog_done = 1'b1;
                result_stall <= 1'b0;
                @(posedge clk);
            end
            else begin
                mode = $urandom_range(0, 99);
                if (mode < 50) begin
                    result_stall <= 1'b0;
                    span = $urandom_range(1, 30);
                end
                else if (mode < 88) begin
                    result_stall <= 1'b1;
                    span = $urandom_range(1, 3);
                end
                else begin
                    result_stall <= 1'b1;
                    span = $urandom_range(20, 80);
                end
                repeat (span) @(posedge clk);
            end
        end
    end

    // Reset, sample side stimulus and end of run
    initial begin : sender
        int          gap;
        int          burst_left;
        int          r;
        logic [9:0]  burst_level;
        logic [9:0]  value;
        logic        fixed;
        logic [6:0]  t_want;
        logic [9:0]  a_want;

        mismatch_count = 0;
        readings_taken = 0;
        quiet_cycles   = 0;
        backlog_done   = 1'b0;
        slot_next      = '0;
        sum_acc        = '0;
        burst_left     = 0;
        burst_level    = '0;
        for (int i = 0; i < RING_DEPTH; i++)
            ring_copy[i] = '0;

        rst_n        <= 1'b0;
        sample_valid <= 1'b0;
        sample       <= '0;
        row_fixed    <= 1'b0;
        row_temp     <= '0;
        row_avg      <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int n = 0; n < TOTAL_READINGS; n++) begin
            if (n < PLAN_LEN) begin
                value  = WARMUP_PLAN[n].value;
                fixed  = WARMUP_PLAN[n].fixed;
                t_want = WARMUP_PLAN[n].temp;
                a_want = WARMUP_PLAN[n].avg;
            end
            else begin
                // Steady bursts settle the mean on a curve edge; the rest is noise
                if (burst_left == 0) begin
                    r = $urandom_range(0, 99);
                    if (r < 45) begin
                        burst_left  = RING_DEPTH + $urandom_range(0, 4);
                        burst_level = curve_level();
                    end
                    else if (r < 90) begin
                        burst_left  = 1;
                        burst_level = 10'($urandom_range(0, 1023));
                    end
                    else begin
                        burst_left  = $urandom_range(1, RING_DEPTH);
                        burst_level = ($urandom_range(0, 1) != 0) ? 10'd1023 : 10'd0;
                    end
                end
                value  = burst_level;
                burst_left--;
                fixed  = 1'b0;
                t_want = '0;
                a_want = '0;
            end

            gap = idle_gap();
            if (gap > 0) begin
                sample_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            sample_valid <= 1'b1;
            sample       <= value;
            row_fixed    <= fixed;
            row_temp     <= t_want;
            row_avg      <= a_want;
            @(posedge clk);
            while (sample_stall)
                @(posedge clk);
        end
        sample_valid <= 1'b0;
        @(posedge clk);

        // Drain, then allow for anything stray
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (pending_readings.size() != 0)
            report_mismatch($sformatf("%0d results never seen", pending_readings.size()));

        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
